FILE: src/dps_pkg.sv
// dps_pkg: shared constants, codes, entry layout and controller/datapath links
// for the device pool selector; no dependencies
package dps_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int LOAD_WIDTH = 16;
  localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int CURSOR_WIDTH = 32;
  localparam int DW = $clog2(CURSOR_WIDTH);
  localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = {LOAD_WIDTH{1'b1}};

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_ACQ    = 3'd2;
  localparam logic [2:0] OP_ADJUST = 3'd3;
  localparam logic [2:0] OP_HEALTH = 3'd4;

  localparam logic [1:0] STRAT_MANUAL = 2'd0;
  localparam logic [1:0] STRAT_RR     = 2'd1;
  localparam logic [1:0] STRAT_LEAST  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;

  typedef struct packed {
    logic [15:0]           id;
    logic [3:0]            kind;
    logic [LOAD_WIDTH-1:0] load;
    logic                  healthy;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DIV, S_SEED, S_SCAN, S_APPLY, S_SHIFT, S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic prep;
    logic div_step;
    logic scan_init;
    logic scan_step;
    logic apply;
    logic shift_step;
    logic shrink;
    logic emit;
    logic rd_pick;
    logic rd_next;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic need_div;
    logic need_scan;
    logic div_last;
    logic scan_stop;
    logic rm_ok;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

FILE: src/dps_ctrl.sv
// dps_ctrl: sequencer for one operation at a time
// depends on dps_pkg
module dps_ctrl import dps_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.prep = 1'b1;
        if (sts.n_zero || !(sts.need_scan || sts.need_div)) state_nxt = S_APPLY;
        else if (sts.need_div) state_nxt = S_DIV;
        else state_nxt = S_SEED;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.scan_init = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_stop) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cmd.rd_pick = 1'b1;
        state_nxt = sts.rm_ok ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd.rd_next = 1'b1;
        if (sts.shift_done) begin
          cmd.shrink = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/dps_datapath.sv
// dps_datapath: entry table, scan and divide registers, result and output words
// depends on dps_pkg
module dps_datapath import dps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_operation,
  input  logic [1:0]  in_strategy,
  input  logic [15:0] in_device_id,
  input  logic        in_id_given,
  input  logic [3:0]  in_device_kind,
  input  logic signed [7:0] in_load_delta,
  input  logic        in_health_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_id,
  output logic [15:0] out_result_load
);

  entry_t slots_r [POOL_DEPTH];

  logic [2:0]  op_r;
  logic [1:0]  strat_r;
  logic [15:0] dev_id_r;
  logic        given_r;
  logic [3:0]  kind_r;
  logic signed [7:0] delta_r;
  logic        health_r;

  logic [CW-1:0]           count_r, count_nxt;
  logic [15:0]             next_id_r, next_id_nxt;
  logic [CURSOR_WIDTH-1:0] cursor_r, cursor_nxt;

  logic [PW-1:0]           idx_r, idx_nxt, pick_r, pick_nxt, rem_r, rem_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    found_r, found_nxt;
  logic [LOAD_WIDTH-1:0]   best_r, best_nxt;
  logic [CURSOR_WIDTH-1:0] dq_r, dq_nxt;
  logic [DW-1:0]           dcnt_r, dcnt_nxt;

  logic [2:0]  res_st_r, res_st_nxt;
  logic [15:0] res_id_r, res_id_nxt;
  logic [15:0] res_ld_r, res_ld_nxt;

  logic        out_valid_r;
  logic [2:0]  out_st_r;
  logic [15:0] out_id_r, out_ld_r;

  logic [PW-1:0] rd_addr, idx_inc, idx_wrap;
  entry_t        rd;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  entry_t        wr_data;

  logic is_acq, mode_rr, mode_ll, hit;
  logic [CW-1:0] last_cnt;
  logic [PW:0]   dtrial;
  logic signed [LOAD_WIDTH+1:0] adj_sum;
  logic [LOAD_WIDTH-1:0] adj_load, inc_load;

  assign is_acq   = (op_r == OP_ACQ);
  assign mode_rr  = is_acq && (strat_r == STRAT_RR);
  assign mode_ll  = is_acq && (strat_r == STRAT_LEAST);
  assign last_cnt = count_r - CW'(1);
  assign idx_inc  = idx_r + PW'(1);
  assign idx_wrap = ({1'b0, idx_r} == (PW+1)'(last_cnt)) ? '0 : idx_inc;

  always_comb begin
    if (cmd.rd_pick) rd_addr = pick_r;
    else if (cmd.rd_next) rd_addr = idx_inc;
    else rd_addr = idx_r;
  end
  assign rd = slots_r[rd_addr];

  // scan hit: id match for lookups, first healthy for round robin
  assign hit = mode_rr ? rd.healthy : (!mode_ll && rd.id == dev_id_r);

  assign dtrial  = {rem_r, dq_r[CURSOR_WIDTH-1]};
  assign adj_sum = $signed({2'b00, rd.load}) + (LOAD_WIDTH+2)'(delta_r);
  assign inc_load = (rd.load == LOAD_MAX) ? rd.load : rd.load + LOAD_WIDTH'(1);

  always_comb begin
    if (adj_sum < 0) adj_load = '0;
    else if (adj_sum > $signed({2'b00, LOAD_MAX})) adj_load = LOAD_MAX;
    else adj_load = adj_sum[LOAD_WIDTH-1:0];
  end

  always_comb begin
    sts.n_zero     = (count_r == '0);
    sts.need_div   = mode_rr;
    sts.need_scan  = (op_r == OP_REMOVE) || (op_r == OP_ADJUST) || (op_r == OP_HEALTH)
                     || (is_acq && strat_r == STRAT_MANUAL && given_r) || mode_ll;
    sts.div_last   = (dcnt_r == DW'(CURSOR_WIDTH - 1));
    sts.scan_stop  = hit || (cnt_r == last_cnt);
    sts.rm_ok      = (op_r == OP_REMOVE) && found_r && (rd.load == '0);
    sts.shift_done = ((CW+1)'(idx_r) + (CW+1)'(1)) >= (CW+1)'(count_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    cursor_nxt  = cursor_r;
    idx_nxt     = idx_r;
    pick_nxt    = pick_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    dq_nxt      = dq_r;
    dcnt_nxt    = dcnt_r;
    res_st_nxt  = res_st_r;
    res_id_nxt  = res_id_r;
    res_ld_nxt  = res_ld_r;
    wr_en       = 1'b0;
    wr_addr     = pick_r;
    wr_data     = rd;

    if (cmd.prep) begin
      rem_nxt   = '0;
      found_nxt = 1'b0;
      dq_nxt    = cursor_r;
      dcnt_nxt  = '0;
    end

    // restoring remainder, one cursor bit a cycle
    if (cmd.div_step) begin
      dq_nxt   = {dq_r[CURSOR_WIDTH-2:0], 1'b0};
      dcnt_nxt = dcnt_r + DW'(1);
      if ((CW+1)'(dtrial) >= (CW+1)'(count_r)) rem_nxt = PW'((CW+1)'(dtrial) - (CW+1)'(count_r));
      else rem_nxt = dtrial[PW-1:0];
    end

    if (cmd.scan_init) begin
      idx_nxt = rem_r;
      cnt_nxt = '0;
    end

    if (cmd.scan_step) begin
      cnt_nxt = cnt_r + CW'(1);
      idx_nxt = idx_wrap;
      if (mode_ll) begin
        if (rd.healthy && (!found_r || rd.load < best_r)) begin
          found_nxt = 1'b1;
          pick_nxt  = idx_r;
          best_nxt  = rd.load;
        end
      end else if (hit) begin
        found_nxt = 1'b1;
        pick_nxt  = idx_r;
      end
    end

    if (cmd.apply) begin
      res_st_nxt = ST_NONE;
      res_id_nxt = '0;
      res_ld_nxt = '0;
      idx_nxt    = pick_r;
      case (op_r)
        OP_ADD: begin
          if ((CW+1)'(count_r) >= (CW+1)'(POOL_DEPTH)) begin
            res_st_nxt = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = count_r[PW-1:0];
            wr_data.id   = next_id_r;
            wr_data.kind = kind_r;
            wr_data.load = '0;
            wr_data.healthy = 1'b1;
            count_nxt    = count_r + CW'(1);
            next_id_nxt  = next_id_r + 16'd1;
            res_st_nxt   = ST_OK;
            res_id_nxt   = next_id_r;
          end
        end
        OP_REMOVE: begin
          if (!found_r) begin
            res_st_nxt = ST_NOTFOUND;
          end else if (rd.load != '0) begin
            res_st_nxt = ST_BUSY;
            res_id_nxt = dev_id_r;
            res_ld_nxt = 16'(rd.load);
          end else begin
            res_st_nxt = ST_OK;
            res_id_nxt = dev_id_r;
          end
        end
        OP_ACQ: begin
          if (count_r != '0) begin
            if (mode_rr) cursor_nxt = cursor_r + CURSOR_WIDTH'(1);
            if (found_r && (strat_r != STRAT_MANUAL || rd.healthy)) begin
              wr_en        = 1'b1;
              wr_data.load = inc_load;
              res_st_nxt   = ST_OK;
              res_id_nxt   = rd.id;
              res_ld_nxt   = 16'(inc_load);
            end else if (strat_r == STRAT_MANUAL && given_r && !found_r) begin
              res_st_nxt = ST_NOTFOUND;
            end
          end
        end
        OP_ADJUST: begin
          if (!found_r) begin
            res_st_nxt = ST_NOTFOUND;
          end else begin
            wr_en        = 1'b1;
            wr_data.load = adj_load;
            res_st_nxt   = ST_OK;
            res_id_nxt   = dev_id_r;
            res_ld_nxt   = 16'(adj_load);
          end
        end
        OP_HEALTH: begin
          if (!found_r) begin
            res_st_nxt = ST_NOTFOUND;
          end else begin
            wr_en           = 1'b1;
            wr_data.healthy = health_r;
            res_st_nxt      = ST_OK;
            res_id_nxt      = dev_id_r;
            res_ld_nxt      = 16'(rd.load);
          end
        end
        default: res_st_nxt = ST_NONE;
      endcase
    end

    // close the gap: entry idx+1 moves down to idx
    if (cmd.shift_step) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = rd;
      idx_nxt = idx_inc;
    end

    if (cmd.shrink) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots_r[wr_addr] <= wr_data;
    if (cmd.latch) begin
      op_r     <= in_operation;
      strat_r  <= in_strategy;
      dev_id_r <= in_device_id;
      given_r  <= in_id_given;
      kind_r   <= in_device_kind;
      delta_r  <= in_load_delta;
      health_r <= in_health_value;
    end
    idx_r    <= idx_nxt;
    pick_r   <= pick_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    dq_r     <= dq_nxt;
    dcnt_r   <= dcnt_nxt;
    res_st_r <= res_st_nxt;
    res_id_r <= res_id_nxt;
    res_ld_r <= res_ld_nxt;
    if (cmd.emit) begin
      out_st_r <= res_st_r;
      out_id_r <= res_id_r;
      out_ld_r <= res_ld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_id_r   <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      cursor_r  <= cursor_nxt;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_result_id   = out_id_r;
  assign out_result_load = out_ld_r;

endmodule

FILE: src/device_pool_selector.sv
// device_pool_selector: top level, joins the sequencer and the datapath
// depends on dps_pkg, dps_ctrl, dps_datapath
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall  | operation, strategy, id, kind, delta, health
//   out_    | output    | out_valid/out_stall| status, result_id, result_load
//
// one operation at a time: set-up, then for round robin the remainder of the 32-bit cursor
// (one bit a cycle), then for lookups, round robin and least loaded a seed step and a scan of
// up to every entry; then apply, for a remove that succeeds a shift of each later entry down
// by one, and last the hand-off to the output register; an empty pool skips divide and scan
// synchronous active-low reset empties the pool; table contents are not cleared
// the finished word sits in the output register while the next operation is taken;
// a stalled output only holds the sequencer in its last state
module device_pool_selector import dps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [1:0]  in_strategy,
  input  logic [15:0] in_device_id,
  input  logic        in_id_given,
  input  logic [3:0]  in_device_kind,
  input  logic signed [7:0] in_load_delta,
  input  logic        in_health_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_id,
  output logic [15:0] out_result_load
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  dps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dps_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_strategy     (in_strategy),
    .in_device_id    (in_device_id),
    .in_id_given     (in_id_given),
    .in_device_kind  (in_device_kind),
    .in_load_delta   (in_load_delta),
    .in_health_value (in_health_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_result_id   (out_result_id),
    .out_result_load (out_result_load)
  );

endmodule

FILE: dv/device_pool_selector_tb.sv
// device_pool_selector_tb: directed table then weighted random operations on the pool
// depends on dps_pkg, device_pool_selector; results checked vs typed answers or a pool model
module device_pool_selector_tb;
  import dps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the package leaves unnamed
  localparam logic [2:0] OP_RSV_LO = 3'd5;
  localparam logic [2:0] OP_RSV_HI = 3'd7;
  localparam logic [1:0] STRAT_RSV = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  strat;
    logic [15:0] id;
    logic        given;
    logic [3:0]  kind;
    logic [7:0]  delta;
    logic        health;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] id;
    logic [15:0] load;
  } rsp_t;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t rsp;
  } row_t;

  logic clk = 0;
  logic rst_n;
  logic in_valid, in_stall, in_id_given, in_health_value;
  logic [2:0] in_operation;
  logic [1:0] in_strategy;
  logic [15:0] in_device_id;
  logic [3:0] in_device_kind;
  logic signed [7:0] in_load_delta;
  logic out_valid, out_stall;
  logic [2:0] out_status;
  logic [15:0] out_result_id, out_result_load;

  device_pool_selector dut (.*);

  always #1 clk = ~clk;

  // pool model: ids, kinds, loads and health in insertion order
  logic [15:0] pool_id[POOL_DEPTH];
  logic [3:0]  pool_kind[POOL_DEPTH];
  logic [15:0] pool_load[POOL_DEPTH];
  logic        pool_ok[POOL_DEPTH];
  int unsigned pool_n;
  logic [15:0] id_next;
  logic [31:0] rr_cursor;

  rsp_t pending_words[$];
  int   mismatches;
  bit   quiet;
  int   stall_left;

  function automatic int find_entry(logic [15:0] id);
    for (int i = 0; i < pool_n; i++) if (pool_id[i] == id) return i;
    return pool_n;
  endfunction

  function automatic rsp_t pool_apply(req_t r);
    rsp_t o;
    int i, pick, start, k, sum;
    bit hit;
    o = '{ST_NONE, 16'd0, 16'd0};
    case (r.op)
      OP_ADD: begin
        if (pool_n >= POOL_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          pool_id[pool_n] = id_next; pool_kind[pool_n] = r.kind;
          pool_load[pool_n] = 0; pool_ok[pool_n] = 1;
          pool_n++;
          o = '{ST_OK, id_next, 16'd0};
          id_next++;
        end
      end
      OP_REMOVE: begin
        i = find_entry(r.id);
        if (i >= pool_n) o.status = ST_NOTFOUND;
        else if (pool_load[i] != 0) o = '{ST_BUSY, r.id, pool_load[i]};
        else begin
          for (; i + 1 < pool_n; i++) begin
            pool_id[i] = pool_id[i+1]; pool_kind[i] = pool_kind[i+1];
            pool_load[i] = pool_load[i+1]; pool_ok[i] = pool_ok[i+1];
          end
          pool_n--;
          o = '{ST_OK, r.id, 16'd0};
        end
      end
      OP_ACQ: begin
        hit = 0; pick = 0;
        if (pool_n == 0) return o;
        if (r.strat == STRAT_MANUAL) begin
          if (!r.given) return o;
          pick = find_entry(r.id);
          if (pick >= pool_n) begin
            o.status = ST_NOTFOUND;
            return o;
          end
          hit = pool_ok[pick];
        end else if (r.strat == STRAT_RR) begin
          start = rr_cursor % pool_n;
          rr_cursor++;
          for (i = 0; i < pool_n; i++) begin
            k = (start + i) % pool_n;
            if (pool_ok[k]) begin
              pick = k; hit = 1; break;
            end
          end
        end else if (r.strat == STRAT_LEAST) begin
          for (i = 0; i < pool_n; i++)
            if (pool_ok[i] && (!hit || pool_load[i] < pool_load[pick])) begin
              pick = i; hit = 1;
            end
        end
        if (!hit) return o;
        if (pool_load[pick] != LOAD_MAX) pool_load[pick]++;
        o = '{ST_OK, pool_id[pick], pool_load[pick]};
      end
      OP_ADJUST: begin
        i = find_entry(r.id);
        if (i >= pool_n) o.status = ST_NOTFOUND;
        else begin
          sum = int'(pool_load[i]) + int'($signed(r.delta));
          pool_load[i] = (sum < 0) ? 16'd0 : (sum > int'(LOAD_MAX)) ? LOAD_MAX : sum[15:0];
          o = '{ST_OK, r.id, pool_load[i]};
        end
      end
      OP_HEALTH: begin
        i = find_entry(r.id);
        if (i >= pool_n) o.status = ST_NOTFOUND;
        else begin
          pool_ok[i] = r.health;
          o = '{ST_OK, r.id, pool_load[i]};
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // drive one word, wait for the handshake, then record what should come back
  task automatic push_word(req_t r, bit typed, rsp_t want);
    int gap;
    rsp_t got;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {in_operation, in_strategy, in_device_id, in_id_given, in_device_kind,
     in_load_delta, in_health_value} <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = pool_apply(r);
    pending_words.push_back(typed ? want : got);
  endtask

  function automatic logic [15:0] pick_id();
    if (pool_n > 0 && $urandom_range(0, 9) < 8) return pool_id[$urandom_range(0, pool_n - 1)];
    return 16'($urandom);
  endfunction

  function automatic req_t rand_req();
    req_t r;
    logic [63:0] raw;
    int w;
    raw = {$urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    r.id = pick_id();
    w = $urandom_range(0, 99);
    if (w < 25) r.op = OP_ADD;
    else if (w < 42) r.op = OP_REMOVE;
    else if (w < 72) begin
      r.op = OP_ACQ;
      r.strat = ($urandom_range(0, 19) == 0) ? STRAT_RSV : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 9) != 0) r.given = 1;
    end else if (w < 86) r.op = OP_ADJUST;
    else if (w < 97) r.op = OP_HEALTH;
    else r.op = 3'($urandom_range(OP_RSV_LO, OP_RSV_HI));
    return r;
  endfunction

  // result side: random stall per word, compare with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %0d %0d %0d",
                                         out_status, out_result_id, out_result_load);
        end else begin
          rsp_t e;
          e = pending_words.pop_front();
          if (e != {out_status, out_result_id, out_result_load}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d id %0d load %0d, got st %0d id %0d load %0d",
                       e.status, e.id, e.load, out_status, out_result_id, out_result_load);
          end
        end
        stall_left <= quiet ? 0 : $urandom_range(0, 16);
        out_stall <= 0;
      end else if (stall_left > 0) begin
        out_stall <= 1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  localparam rsp_t NIL = '{ST_NONE, 16'd0, 16'd0};
  localparam req_t Z = '0;

  // directed rows: typed answers only where they are plain
  row_t dir_rows[$];
  function automatic row_t mk(logic [2:0] op, logic [1:0] st, logic [15:0] id, logic g,
                              logic [3:0] k, logic [7:0] d, logic h,
                              logic typed, rsp_t want);
    return '{'{op, st, id, g, k, d, h}, typed, want};
  endfunction

  initial begin
    in_valid <= 0; rst_n <= 0;
    {in_operation, in_strategy, in_device_id, in_id_given, in_device_kind,
     in_load_delta, in_health_value} <= Z;
    pool_n = 0; id_next = 0; rr_cursor = 0; quiet = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    dir_rows = '{
      mk(OP_ACQ, STRAT_RR, 0, 1, 0, 0, 0, 1, NIL),              // empty pool
      mk(OP_REMOVE, 0, 5, 0, 0, 0, 0, 1, '{ST_NOTFOUND, 0, 0}),
      mk(OP_ADD, 0, 0, 0, 15, 0, 0, 1, '{ST_OK, 0, 0}),
      mk(OP_ADD, 0, 16'hffff, 1, 0, 8'hff, 1, 1, '{ST_OK, 1, 0}),
      mk(OP_ACQ, STRAT_MANUAL, 0, 0, 0, 0, 0, 1, NIL),          // manual with no id
      mk(OP_ACQ, STRAT_MANUAL, 0, 1, 0, 0, 0, 1, '{ST_OK, 0, 1}),
      mk(OP_REMOVE, 0, 0, 0, 0, 0, 0, 1, '{ST_BUSY, 0, 1}),     // loaded entry
      mk(OP_ADJUST, 0, 0, 0, 0, 8'h80, 0, 1, '{ST_OK, 0, 0}),   // clamp at zero
      mk(OP_ADJUST, 0, 1, 0, 0, 8'h7f, 0, 1, '{ST_OK, 1, 127}),
      mk(OP_ACQ, STRAT_LEAST, 0, 0, 0, 0, 0, 0, NIL),
      mk(OP_ACQ, STRAT_RR, 0, 0, 0, 0, 0, 0, NIL),
      mk(OP_ACQ, STRAT_RSV, 0, 1, 0, 0, 0, 1, NIL),
      mk(OP_RSV_LO, 0, 0, 0, 0, 0, 0, 1, NIL),
      mk(OP_RSV_HI, 3, 16'hffff, 1, 15, 8'h7f, 1, 1, NIL),
      mk(OP_HEALTH, 0, 0, 0, 0, 0, 0, 0, NIL),
      mk(OP_ACQ, STRAT_MANUAL, 0, 1, 0, 0, 0, 1, NIL),          // unhealthy target
      mk(OP_HEALTH, 0, 1, 0, 0, 0, 0, 0, NIL),
      mk(OP_ACQ, STRAT_LEAST, 0, 0, 0, 0, 0, 1, NIL),           // nobody healthy
      mk(OP_ACQ, STRAT_RR, 0, 0, 0, 0, 0, 1, NIL),
      mk(OP_HEALTH, 0, 0, 0, 0, 0, 1, 0, NIL),
      mk(OP_HEALTH, 0, 1, 0, 0, 0, 1, 0, NIL),
      mk(OP_ADJUST, 0, 0, 0, 0, 8'hff, 0, 0, NIL),
      mk(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, NIL),
      mk(OP_REMOVE, 0, 16'hffff, 0, 0, 0, 0, 1, '{ST_NOTFOUND, 0, 0})
    };
    foreach (dir_rows[i]) push_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    // directed rows, the saturation pump and the random words add up to about 900
    for (int n = 0; n < 360; n++) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == 150 && pool_n > 0) begin
        req_t p;
        // pump one entry to load saturation, then acquire on top of it
        p = Z; p.op = OP_ADJUST; p.id = pool_id[0]; p.delta = 8'h7f;
        repeat (520) push_word(p, 0, NIL);
        p.op = OP_ACQ; p.strat = STRAT_MANUAL; p.given = 1; p.health = 1;
        push_word(p, 0, NIL);
      end
      push_word(rand_req(), 0, NIL);
    end
    in_valid <= 0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
src/dps_pkg.sv
src/dps_ctrl.sv
src/dps_datapath.sv
src/device_pool_selector.sv
dv/device_pool_selector_tb.sv
